FILE: hw/rtl/tracker_url_stream_parser_top_defines.svh
// Assertion helpers shared by the parser RTL.
// Each macro expects clk and rst_n in scope.
`ifndef TRACKER_URL_STREAM_PARSER_TOP_DEFINES_SVH
`define TRACKER_URL_STREAM_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, sampled at the rising edge, off during reset.
`define TUSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled at the rising edge, off during reset.
`define TUSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/tusp_pkg.sv
package tusp_pkg;

    // Parse phases: scheme match positions, then the URL sections
    localparam logic [3:0] PH_S0    = 4'd0;
    localparam logic [3:0] PH_H1    = 4'd1;
    localparam logic [3:0] PH_H2    = 4'd2;
    localparam logic [3:0] PH_H3    = 4'd3;
    localparam logic [3:0] PH_U1    = 4'd5;
    localparam logic [3:0] PH_U2    = 4'd6;
    localparam logic [3:0] PH_COLON = 4'd7;
    localparam logic [3:0] PH_SL1   = 4'd8;
    localparam logic [3:0] PH_SL2   = 4'd9;
    localparam logic [3:0] PH_HOST  = 4'd10;
    localparam logic [3:0] PH_PORT  = 4'd11;
    localparam logic [3:0] PH_PATH  = 4'd12;
    localparam logic [3:0] PH_REJ   = 4'd13;

    // Character classes
    localparam logic [2:0] CLS_SCHEME = 3'd0;
    localparam logic [2:0] CLS_HOST   = 3'd1;
    localparam logic [2:0] CLS_PORT   = 3'd2;
    localparam logic [2:0] CLS_PATH   = 3'd3;
    localparam logic [2:0] CLS_REJECT = 3'd4;

    // Protocol codes
    localparam logic [1:0] PROTO_NONE = 2'd0;
    localparam logic [1:0] PROTO_HTTP = 2'd1;
    localparam logic [1:0] PROTO_UDP  = 2'd2;

    // Port scan stages
    localparam logic [1:0] PST_LEAD = 2'd0;
    localparam logic [1:0] PST_NUM  = 2'd1;
    localparam logic [1:0] PST_STOP = 2'd2;

    // Character constants
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [15:0] PORT_HTTP_DEF = 16'd80;
    localparam logic [15:0] PORT_UDP_DEF  = 16'd2710;
    localparam logic [16:0] PORT_SAT      = 17'h10000;

    // Control from the phase logic to the port scanner
    typedef struct packed {
        logic take;   // a byte is accepted this cycle
        logic feed;   // the byte is port text
        logic open;   // the byte is the ':' that opens the port
        logic clear;  // the byte closes the URL
    } port_ctl_t;

    // Port status after the current byte
    typedef struct packed {
        logic        explicit_port;
        logic        in_range;
        logic [15:0] value;
    } port_stat_t;

    // One result word
    typedef struct packed {
        logic [2:0]  char_class;
        logic        done_res;
        logic [1:0]  protocol;
        logic [15:0] port;
        logic        url_ok;
    } res_t;

endpackage

FILE: hw/rtl/tusp_port_scan.sv
`include "tracker_url_stream_parser_top_defines.svh"

module tusp_port_scan
    import tusp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  port_ctl_t  ctl,
    input  logic [7:0] ch,
    output port_stat_t stat
);

    logic [16:0] acc_reg;
    logic [16:0] acc_next;
    logic [1:0]  stage_reg;
    logic [1:0]  stage_next;
    logic        neg_reg;
    logic        neg_next;
    logic        expl_reg;
    logic        expl_next;
    logic [19:0] mac;
    logic        is_digit;
    logic        is_space;

    assign is_digit = (ch inside {[8'h30:8'h39]});
    assign is_space = (ch == CH_SPACE) || (ch inside {[8'h09:8'h0D]});

    // Multiply by ten and add the digit
    assign mac = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0} + {16'd0, ch[3:0]};

    // Step the atoi scan by one byte
    always_comb
    begin
        acc_next   = acc_reg;
        stage_next = stage_reg;
        neg_next   = neg_reg;
        expl_next  = expl_reg | ctl.open;
        if (ctl.feed && (stage_reg == PST_LEAD || stage_reg == PST_NUM))
        begin
            if (is_digit)
            begin
                acc_next   = (mac >= {3'b000, PORT_SAT}) ? PORT_SAT : mac[16:0];
                stage_next = PST_NUM;
            end
            else if (stage_reg == PST_LEAD && is_space)
            begin
                stage_next = PST_LEAD;
            end
            else if (stage_reg == PST_LEAD && (ch == CH_PLUS || ch == CH_MINUS))
            begin
                neg_next   = (ch == CH_MINUS);
                stage_next = PST_NUM;
            end
            else
            begin
                stage_next = PST_STOP;
            end
        end
    end

    // Report status as it stands after this byte
    assign stat.explicit_port = expl_next;
    assign stat.in_range      = !acc_next[16] && (!neg_next || acc_next == 17'd0);
    assign stat.value         = acc_next[15:0];

    // Commit on accept, clear at the end of a URL
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            stage_reg <= PST_LEAD;
            neg_reg   <= 1'b0;
            expl_reg  <= 1'b0;
        end
        else if (ctl.take)
        begin
            if (ctl.clear)
            begin
                acc_reg   <= '0;
                stage_reg <= PST_LEAD;
                neg_reg   <= 1'b0;
                expl_reg  <= 1'b0;
            end
            else
            begin
                acc_reg   <= acc_next;
                stage_reg <= stage_next;
                neg_reg   <= neg_next;
                expl_reg  <= expl_next;
            end
        end
    end

    `TUSP_ASSERT_NOW(a_acc_sat, 1'b1, acc_reg <= PORT_SAT, "port accumulator above saturation")
    `TUSP_ASSERT_NOW(a_stage_code, 1'b1, stage_reg != 2'd3, "port scan stage corrupt")
    `TUSP_ASSERT_NEXT(a_clear, ctl.take && ctl.clear,
        acc_reg == 17'd0 && !expl_reg && !neg_reg, "port state not cleared after URL")

endmodule

FILE: hw/rtl/tracker_url_stream_parser_top.sv
// Channel | Handshake              | Payload
// --------+------------------------+-------------------------------------------
// byte    | byte_valid, byte_stall | ch, last
// res     | res_valid, res_stall   | char_class, done_res, protocol, port, url_ok
//
// One byte is taken per cycle while byte_stall is low; its result is registered.
// Throughput is set by the single phase and port update done per byte.
// A two-entry output (result register plus skid) takes one more byte
// after res_stall rises; byte_stall is the skid's full flag.
// Reset clears the phase, the port scanner and both output entries.
`include "tracker_url_stream_parser_top_defines.svh"

module tracker_url_stream_parser_top
    import tusp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  ch,
    input  logic        last,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [2:0]  char_class,
    output logic        done_res,
    output logic [1:0]  protocol,
    output logic [15:0] port,
    output logic        url_ok
);

    logic       at_start;
    logic [3:0] ph_reg;
    logic [3:0] ph_next;
    logic [1:0] proto_reg;
    logic [1:0] proto_next;
    logic       host_seen_reg;
    logic       host_seen_next;
    logic       path_seen_reg;
    logic       path_seen_next;
    logic [2:0] cls;
    logic [7:0] low;
    logic       take;
    logic       feed;
    logic       open;
    logic       closed_ok;
    port_ctl_t  pctl;
    port_stat_t pstat;
    res_t       res_new;
    res_t       res_reg;
    res_t       skid_reg;
    logic       res_valid_reg;
    logic       skid_valid_reg;

    assign at_start  = (ph_reg == PH_S0);
    assign take      = byte_valid && !skid_valid_reg;
    assign low       = (ch inside {[8'h41:8'h5A]}) ? ch + 8'd32 : ch;

    // Advance the phase for this word
    always_comb
    begin
        ph_next        = ph_reg;
        proto_next     = proto_reg;
        host_seen_next = host_seen_reg;
        path_seen_next = path_seen_reg;
        feed           = 1'b0;
        open           = 1'b0;
        cls            = CLS_REJECT;
        if (ph_reg < PH_HOST)
        begin
            ph_next = PH_REJ;
            case (ph_reg)
                PH_S0:
                begin
                    if (low == CH_H)
                        ph_next = PH_H1;
                    else if (low == CH_U)
                        ph_next = PH_U1;
                end
                PH_H1:    if (low == CH_T) ph_next = PH_H2;
                PH_H2:    if (low == CH_T) ph_next = PH_H3;
                PH_H3:
                begin
                    if (low == CH_P)
                    begin
                        ph_next    = PH_COLON;
                        proto_next = PROTO_HTTP;
                    end
                end
                PH_U1:    if (low == CH_D) ph_next = PH_U2;
                PH_U2:
                begin
                    if (low == CH_P)
                    begin
                        ph_next    = PH_COLON;
                        proto_next = PROTO_UDP;
                    end
                end
                PH_COLON: if (ch == CH_COLON) ph_next = PH_SL1;
                PH_SL1:   if (ch == CH_SLASH) ph_next = PH_SL2;
                PH_SL2:   if (ch == CH_SLASH) ph_next = PH_HOST;
                default:  ph_next = PH_REJ;
            endcase
            cls = (ph_next == PH_REJ) ? CLS_REJECT : CLS_SCHEME;
        end
        else if (ph_reg == PH_HOST)
        begin
            if (ch == CH_SLASH)
            begin
                ph_next        = PH_PATH;
                path_seen_next = 1'b1;
                cls            = CLS_PATH;
            end
            else if (ch == CH_COLON)
            begin
                ph_next = PH_PORT;
                open    = 1'b1;
                cls     = CLS_PORT;
            end
            else
            begin
                host_seen_next = 1'b1;
                cls            = CLS_HOST;
            end
        end
        else if (ph_reg == PH_PORT)
        begin
            if (ch == CH_SLASH)
            begin
                ph_next        = PH_PATH;
                path_seen_next = 1'b1;
                cls            = CLS_PATH;
            end
            else
            begin
                feed = 1'b1;
                cls  = CLS_PORT;
            end
        end
        else if (ph_reg == PH_PATH)
        begin
            cls = CLS_PATH;
        end
        else
        begin
            ph_next = PH_REJ;
        end
    end

    // Drive the port scanner
    assign pctl.take  = take;
    assign pctl.feed  = feed;
    assign pctl.open  = open;
    assign pctl.clear = last;

    tusp_port_scan u_port_scan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (pctl),
        .ch    (ch),
        .stat  (pstat)
    );

    // Build the result word, summary fields only on the closing word
    assign closed_ok = last && (ph_next >= PH_HOST) && (ph_next <= PH_PATH);

    always_comb
    begin
        res_new.char_class = cls;
        res_new.done_res   = last;
        res_new.protocol   = PROTO_NONE;
        res_new.port       = 16'd0;
        res_new.url_ok     = 1'b0;
        if (closed_ok)
        begin
            res_new.protocol = proto_next;
            if (pstat.explicit_port)
                res_new.port = pstat.in_range ? pstat.value : 16'd0;
            else
                res_new.port = (proto_next == PROTO_HTTP) ? PORT_HTTP_DEF : PORT_UDP_DEF;
            res_new.url_ok = host_seen_next
                && (!pstat.explicit_port || pstat.in_range)
                && (proto_next != PROTO_HTTP || path_seen_next);
        end
    end

    // Commit parse state, drop it all after the last word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg        <= PH_S0;
            proto_reg     <= PROTO_NONE;
            host_seen_reg <= 1'b0;
            path_seen_reg <= 1'b0;
        end
        else if (take)
        begin
            if (last)
            begin
                ph_reg        <= PH_S0;
                proto_reg     <= PROTO_NONE;
                host_seen_reg <= 1'b0;
                path_seen_reg <= 1'b0;
            end
            else
            begin
                ph_reg        <= ph_next;
                proto_reg     <= proto_next;
                host_seen_reg <= host_seen_next;
                path_seen_reg <= path_seen_next;
            end
        end
    end

    // Output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (!res_stall)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!res_valid_reg || !res_stall)
        begin
            res_valid_reg <= take;
        end
        else if (take)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (!res_stall)
                res_reg <= skid_reg;
        end
        else if (!res_valid_reg || !res_stall)
        begin
            if (take)
                res_reg <= res_new;
        end
        else if (take)
        begin
            skid_reg <= res_new;
        end
    end

    assign byte_stall = skid_valid_reg;
    assign res_valid  = res_valid_reg;
    assign char_class = res_reg.char_class;
    assign done_res   = res_reg.done_res;
    assign protocol   = res_reg.protocol;
    assign port       = res_reg.port;
    assign url_ok     = res_reg.url_ok;

    `TUSP_ASSERT_NOW(a_skid_behind, skid_valid_reg, res_valid_reg,
        "skid entry full while result register empty")
    `TUSP_ASSERT_NOW(a_open_quiet, res_valid_reg && !res_reg.done_res,
        res_reg.protocol == PROTO_NONE && res_reg.port == 16'd0 && !res_reg.url_ok,
        "summary fields set on a word that does not close the URL")
    `TUSP_ASSERT_NOW(a_ok_proto, res_valid_reg && res_reg.url_ok,
        res_reg.done_res && res_reg.protocol != PROTO_NONE,
        "URL passed without a known protocol")
    `TUSP_ASSERT_NEXT(a_restart, take && last, at_start && proto_reg == PROTO_NONE,
        "parser not back at scheme start after last word")

endmodule
